// File: hdl/hmti_pkg.sv
// shared types and constants of the heightmap triangle interpolator
package hmti_pkg;

   localparam int INDEX_W   = 14;
   localparam int HEIGHT_W  = 16;
   localparam int POS_W     = 15;
   localparam int RESULT_W  = 32;
   localparam int GRID_W    = 8;
   localparam int SCALE_W   = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [GRID_W-1:0]  COLUMNS_RESET = 8'd128;
   localparam logic [GRID_W-1:0]  ROWS_RESET    = 8'd128;
   localparam logic [SCALE_W-1:0] SCALE_RESET   = 16'd256;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_WRITE_DONE  = 2'd1,
      STATUS_OUT_OF_GRID = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_COLUMNS = 2'd0,
      REG_ROWS    = 2'd1,
      REG_SCALE   = 2'd2
   } reg_index_type;

endpackage

// File: hdl/hmti_req_if.sv
// request channel: write or query beats into the interpolator
interface hmti_req_if;
   import hmti_pkg::*;

   logic                       valid;
   logic                       ready;
   op_type                     op;
   logic [INDEX_W-1:0]         entry_index;
   logic signed [HEIGHT_W-1:0] entry_height;
   logic [POS_W-1:0]           query_x;
   logic [POS_W-1:0]           query_z;

   modport source (
      output valid, op, entry_index, entry_height, query_x, query_z,
      input  ready
   );

   modport sink (
      input  valid, op, entry_index, entry_height, query_x, query_z,
      output ready
   );
endinterface

// File: hdl/hmti_rsp_if.sv
// response channel: status and scaled height beats out of the interpolator
interface hmti_rsp_if;
   import hmti_pkg::*;

   logic                       valid;
   logic                       ready;
   status_type                 status;
   logic signed [RESULT_W-1:0] height_out;

   modport source (
      output valid, status, height_out,
      input  ready
   );

   modport sink (
      input  valid, status, height_out,
      output ready
   );
endinterface

// File: hdl/hmti_store.sv
// height store: two copies, each with one write port and two registered read ports
module hmti_store #(
   parameter int DEPTH = 16384,
   parameter int AW    = 14
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [AW-1:0]                       wr_addr,
   input  logic [hmti_pkg::HEIGHT_W-1:0]       wr_data,
   input  logic                                rd_en,
   input  logic [3:0][AW-1:0]                  rd_addr,
   output logic [3:0][hmti_pkg::HEIGHT_W-1:0]  rd_data
);
   import hmti_pkg::*;

   // copy a serves the near row of the cell, copy b the far row
   logic [HEIGHT_W-1:0] mem_a_ff [DEPTH];
   logic [HEIGHT_W-1:0] mem_b_ff [DEPTH];
   logic [3:0][HEIGHT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a_ff[wr_addr] <= wr_data;
         mem_b_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff[0] <= mem_a_ff[rd_addr[0]];
         rd_data_ff[1] <= mem_a_ff[rd_addr[1]];
         rd_data_ff[2] <= mem_b_ff[rd_addr[2]];
         rd_data_ff[3] <= mem_b_ff[rd_addr[3]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/heightmap_triangle_interpolator.sv
// top level: heightmap store with pipelined triangle interpolation
//
// usage
//   req_bus carries one beat per item: op selects a height write
//   (entry_index, entry_height) or a query (query_x, query_z, unsigned
//   fixed point with FRAC_BITS fraction bits). every beat gives exactly one
//   rsp_bus beat, in order: status write done, query ok with the scaled
//   Q24.8 height, or out of grid with a zero height.
//   grid size and height scale sit in three apb registers at 0x0, 0x4, 0x8;
//   change them only while no beat is in flight.
// pipeline and throughput
//   seven register stages: a beat accepted into stage 1 moves through
//   stages 2 to 7, and stage 7 drives rsp_bus. one beat per cycle sustained
//   while rsp_bus.ready stays high; the four corner reads come from two
//   copies of the store, each with two read ports, so the memory never limits the rate.
// reset
//   synchronous reset empties the pipeline and restores the registers
//   (128 columns, 128 rows, scale 1.0). store contents stay undefined
//   until written, no clearing pass is run.
// stall
//   each stage holds while the next one is full and stalled; bubbles close
//   up, so req_bus.ready stays high until every stage holds a beat.
module heightmap_triangle_interpolator #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_ROWS    = 128,
   parameter int FRAC_BITS   = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   hmti_req_if.sink                          req_bus,
   hmti_rsp_if.source                        rsp_bus,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [hmti_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [hmti_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [hmti_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import hmti_pkg::*;

   localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
   localparam int AW     = $clog2(DEPTH);
   localparam int FW     = FRAC_BITS;
   localparam int WW     = FW + 1;          // weight 0..ONE
   localparam int DW     = HEIGHT_W + 1;    // corner difference
   localparam int PW     = DW + WW + 1;     // weighted difference
   localparam int ACC_W  = PW + 2;          // plane height times ONE
   localparam int SC_W   = ACC_W + SCALE_W + 1;
   localparam int RND_W  = SC_W + 1;

   localparam logic [WW-1:0]           ONE        = {1'b1, {FW{1'b0}}};
   localparam logic [POS_W-1:0]        FRAC_MASK  = POS_W'((64'd1 << FW) - 64'd1);
   localparam logic signed [RND_W-1:0] ROUND_HALF = RND_W'(64'd1 << (FW - 1));

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [GRID_W-1:0]  cols_ff, cols_in;
   logic [GRID_W-1:0]  rows_ff, rows_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic               csr_write;
   logic [GRID_W-1:0]  cols_eff;
   logic [GRID_W-1:0]  rows_eff;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      cols_in  = cols_ff;
      rows_in  = rows_ff;
      scale_in = scale_ff;
      if (csr_write) begin
         case (reg_index_type'(paddr[3:2]))
            REG_COLUMNS: cols_in  = pwdata[GRID_W-1:0];
            REG_ROWS:    rows_in  = pwdata[GRID_W-1:0];
            REG_SCALE:   scale_in = pwdata[SCALE_W-1:0];
            default: ;   // unused address, write dropped
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(paddr[3:2]))
         REG_COLUMNS: prdata = CSR_DATA_W'(cols_ff);
         REG_ROWS:    prdata = CSR_DATA_W'(rows_ff);
         REG_SCALE:   prdata = CSR_DATA_W'(scale_ff);
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= COLUMNS_RESET;
         rows_ff  <= ROWS_RESET;
         scale_ff <= SCALE_RESET;
      end else begin
         cols_ff  <= cols_in;
         rows_ff  <= rows_in;
         scale_ff <= scale_in;
      end
   end

   // grid registers above the store size act as the store size
   assign cols_eff = (32'(cols_ff) > 32'(MAX_COLUMNS)) ? GRID_W'(MAX_COLUMNS) : cols_ff;
   assign rows_eff = (32'(rows_ff) > 32'(MAX_ROWS))    ? GRID_W'(MAX_ROWS)    : rows_ff;

   // ---------------------------------------------------------------
   // stage load enables: a stage loads when empty or when it drains
   // ---------------------------------------------------------------
   logic ld1, ld2, ld3, ld4, ld5, ld6, ld7;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;

   assign ld7 = !v7_ff || rsp_bus.ready;
   assign ld6 = !v6_ff || ld7;
   assign ld5 = !v5_ff || ld6;
   assign ld4 = !v4_ff || ld5;
   assign ld3 = !v3_ff || ld4;
   assign ld2 = !v2_ff || ld3;
   assign ld1 = !v1_ff || ld2;

   assign req_bus.ready = ld1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         if (ld1) v1_ff <= req_bus.valid;
         if (ld2) v2_ff <= v1_ff;
         if (ld3) v3_ff <= v2_ff;
         if (ld4) v4_ff <= v3_ff;
         if (ld5) v5_ff <= v4_ff;
         if (ld6) v6_ff <= v5_ff;
         if (ld7) v7_ff <= v6_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 1: registered request beat, split position, bounds, status, weights, cell base
   // ---------------------------------------------------------------
   op_type                     op1_ff;
   logic [INDEX_W-1:0]         idx1_ff;
   logic signed [HEIGHT_W-1:0] hgt1_ff;
   logic [POS_W-1:0]           qx1_ff;
   logic [POS_W-1:0]           qz1_ff;

   always_ff @(posedge clock) begin
      if (ld1) begin
         op1_ff  <= req_bus.op;
         idx1_ff <= req_bus.entry_index;
         hgt1_ff <= req_bus.entry_height;
         qx1_ff  <= req_bus.query_x;
         qz1_ff  <= req_bus.query_z;
      end
   end

   logic [POS_W-1:0] ix1, iz1;
   logic [FW-1:0]    fx1, fz1;
   logic [FW:0]      fsum1;
   logic             oob1;
   logic [31:0]      base1;
   logic [31:0]      widx1;
   status_type       status2_in;
   logic [WW-1:0]    wu2_in, wv2_in;

   always_comb begin
      ix1   = qx1_ff >> FW;
      iz1   = qz1_ff >> FW;
      fx1   = FW'(qx1_ff & FRAC_MASK);
      fz1   = FW'(qz1_ff & FRAC_MASK);
      fsum1 = {1'b0, fx1} + {1'b0, fz1};
      oob1  = (32'(ix1) + 32'd1 >= 32'(cols_eff)) || (32'(iz1) + 32'd1 >= 32'(rows_eff));
      base1 = 32'(ix1) + 32'(iz1) * 32'(cols_eff);
      widx1 = 32'(idx1_ff);

      if (op1_ff == OP_WRITE) begin
         status2_in = STATUS_WRITE_DONE;
      end else if (oob1) begin
         status2_in = STATUS_OUT_OF_GRID;
      end else begin
         status2_in = STATUS_OK;
      end

      // fx+fz >= ONE (exact diagonal included) takes the upper triangle
      if (fsum1[FW]) begin
         wu2_in = ONE - WW'(fx1);
         wv2_in = ONE - WW'(fz1);
      end else begin
         wu2_in = WW'(fx1);
         wv2_in = WW'(fz1);
      end
   end

   // ---------------------------------------------------------------
   // stage 2: store access, write port and corner addresses
   // ---------------------------------------------------------------
   status_type                 status2_ff;
   logic                       wen2_ff;
   logic [AW-1:0]              waddr2_ff;
   logic [HEIGHT_W-1:0]        hgt2_ff;
   logic [31:0]                base2_ff;
   logic                       upper2_ff;
   logic [WW-1:0]              wu2_ff, wv2_ff;

   always_ff @(posedge clock) begin
      if (ld2) begin
         status2_ff <= status2_in;
         wen2_ff    <= (op1_ff == OP_WRITE) && (widx1 < 32'(DEPTH));
         waddr2_ff  <= widx1[AW-1:0];
         hgt2_ff    <= hgt1_ff;
         base2_ff   <= base1;
         upper2_ff  <= fsum1[FW];
         wu2_ff     <= wu2_in;
         wv2_ff     <= wv2_in;
      end
   end

   logic [31:0]                       addr_far2;
   logic [3:0][AW-1:0]                rd_addr2;
   logic [3:0][HEIGHT_W-1:0]          corner3;
   logic                              store_wr;

   // writes go in at the same stage the reads leave, so a query always
   // sees every write accepted ahead of it
   assign store_wr  = ld3 && v2_ff && wen2_ff;
   assign addr_far2 = base2_ff + 32'(cols_eff);

   always_comb begin
      rd_addr2[0] = base2_ff[AW-1:0];
      rd_addr2[1] = AW'(base2_ff + 32'd1);
      rd_addr2[2] = addr_far2[AW-1:0];
      rd_addr2[3] = AW'(addr_far2 + 32'd1);
   end

   hmti_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (waddr2_ff),
      .wr_data (hgt2_ff),
      .rd_en   (ld3),
      .rd_addr (rd_addr2),
      .rd_data (corner3)
   );

   // ---------------------------------------------------------------
   // stage 3: corners ready, pick triangle, weighted differences
   // ---------------------------------------------------------------
   status_type    status3_ff;
   logic          upper3_ff;
   logic [WW-1:0] wu3_ff, wv3_ff;

   always_ff @(posedge clock) begin
      if (ld3) begin
         status3_ff <= status2_ff;
         upper3_ff  <= upper2_ff;
         wu3_ff     <= wu2_ff;
         wv3_ff     <= wv2_ff;
      end
   end

   logic signed [HEIGHT_W-1:0] hb3, hu3, hv3;
   logic signed [DW-1:0]       du3, dv3;
   logic signed [PW-1:0]       pu4_in, pv4_in;

   always_comb begin
      // lower: h0 + fx*(h1-h0) + fz*(h2-h0)
      // upper: h3 + (1-fx)*(h2-h3) + (1-fz)*(h1-h3)
      if (upper3_ff) begin
         hb3 = $signed(corner3[3]);
         hu3 = $signed(corner3[2]);
         hv3 = $signed(corner3[1]);
      end else begin
         hb3 = $signed(corner3[0]);
         hu3 = $signed(corner3[1]);
         hv3 = $signed(corner3[2]);
      end
      du3    = DW'(hu3) - DW'(hb3);
      dv3    = DW'(hv3) - DW'(hb3);
      pu4_in = du3 * $signed({1'b0, wu3_ff});
      pv4_in = dv3 * $signed({1'b0, wv3_ff});
   end

   // ---------------------------------------------------------------
   // stage 4: sum the plane
   // ---------------------------------------------------------------
   status_type                 status4_ff;
   logic signed [HEIGHT_W-1:0] hb4_ff;
   logic signed [PW-1:0]       pu4_ff, pv4_ff;

   always_ff @(posedge clock) begin
      if (ld4) begin
         status4_ff <= status3_ff;
         hb4_ff     <= hb3;
         pu4_ff     <= pu4_in;
         pv4_ff     <= pv4_in;
      end
   end

   logic signed [ACC_W-1:0] acc5_in;

   assign acc5_in = (ACC_W'(hb4_ff) <<< FW) + ACC_W'(pu4_ff) + ACC_W'(pv4_ff);

   // ---------------------------------------------------------------
   // stage 5: apply height scale
   // ---------------------------------------------------------------
   status_type              status5_ff;
   logic signed [ACC_W-1:0] acc5_ff;

   always_ff @(posedge clock) begin
      if (ld5) begin
         status5_ff <= status4_ff;
         acc5_ff    <= acc5_in;
      end
   end

   logic signed [SC_W-1:0] sc6_in;

   assign sc6_in = acc5_ff * $signed({1'b0, scale_ff});

   // ---------------------------------------------------------------
   // stage 6: round half up to Q24.8, saturate
   // ---------------------------------------------------------------
   status_type             status6_ff;
   logic signed [SC_W-1:0] sc6_ff;

   always_ff @(posedge clock) begin
      if (ld6) begin
         status6_ff <= status5_ff;
         sc6_ff     <= sc6_in;
      end
   end

   logic signed [RND_W-1:0]    rnd6;
   logic signed [RND_W-1:0]    shr6;
   logic                       pos_ovf6, neg_ovf6;
   logic signed [RESULT_W-1:0] sat6;
   logic signed [RESULT_W-1:0] height7_in;

   always_comb begin
      rnd6     = RND_W'(sc6_ff) + ROUND_HALF;
      shr6     = rnd6 >>> FW;    // floor shift
      pos_ovf6 = !shr6[RND_W-1] && (|shr6[RND_W-2:RESULT_W-1]);
      neg_ovf6 = shr6[RND_W-1] && !(&shr6[RND_W-2:RESULT_W-1]);
      if (pos_ovf6) begin
         sat6 = {1'b0, {(RESULT_W-1){1'b1}}};
      end else if (neg_ovf6) begin
         sat6 = {1'b1, {(RESULT_W-1){1'b0}}};
      end else begin
         sat6 = shr6[RESULT_W-1:0];
      end
      height7_in = (status6_ff == STATUS_OK) ? sat6 : '0;
   end

   // ---------------------------------------------------------------
   // stage 7: response register
   // ---------------------------------------------------------------
   status_type                 status7_ff;
   logic signed [RESULT_W-1:0] height7_ff;

   always_ff @(posedge clock) begin
      if (ld7) begin
         status7_ff <= status6_ff;
         height7_ff <= height7_in;
      end
   end

   assign rsp_bus.valid      = v7_ff;
   assign rsp_bus.status     = status7_ff;
   assign rsp_bus.height_out = height7_ff;

endmodule

// File: hdl/hmti_checker.sv
// port-level checker for the interpolator and its bind
module hmti_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input hmti_pkg::status_type              rsp_status,
   input logic [hmti_pkg::RESULT_W-1:0]     rsp_height_out,
   input logic                              psel,
   input logic                              penable,
   input logic                              pwrite,
   input logic [hmti_pkg::CSR_ADDR_W-1:0]   paddr,
   input logic [hmti_pkg::CSR_DATA_W-1:0]   pwdata,
   input logic [hmti_pkg::CSR_DATA_W-1:0]   prdata
);
   import hmti_pkg::*;

   // anything but a good query carries a zero height
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_height_out == '0)
      else $error("nonzero height on a non-ok response");

   // reset empties the pipeline
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response beat right after reset");

   // a scale write reads back on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(psel && penable && pwrite && paddr[3:2] == REG_SCALE)
         && paddr[3:2] == REG_SCALE
      |-> prdata[SCALE_W-1:0] == $past(pwdata[SCALE_W-1:0]))
      else $error("height scale readback mismatch");

   // stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready
      |=> rsp_valid && $stable(rsp_status) && $stable(rsp_height_out))
      else $error("stalled response beat changed");

endmodule

bind heightmap_triangle_interpolator hmti_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_status     (rsp_bus.status),
   .rsp_height_out (rsp_bus.height_out),
   .psel           (psel),
   .penable        (penable),
   .pwrite         (pwrite),
   .paddr          (paddr),
   .pwdata         (pwdata),
   .prdata         (prdata)
);
